>>> hw/rtl/sih_pkg.sv
package sih_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int HASH_W = 64;
   localparam int HANDLE_W = 8;

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [HASH_W-1:0] FNV_PRIME_LOW = 64'h00000000000001b3;
   localparam int FNV_PRIME_SHIFT = 40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic                found;
      logic                table_full;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [HASH_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_cmd_type;

   // The prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply.
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {{(HASH_W-8){1'b0}}, b};
      return (x << FNV_PRIME_SHIFT) + (x * FNV_PRIME_LOW);
   endfunction

   function automatic logic [HANDLE_W-1:0] to_handle(input logic [CNT_W-1:0] idx);
      return HANDLE_W'(idx);
   endfunction

endpackage

>>> hw/rtl/sih_hash.sv
module sih_hash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fold_en,
   input  sih_pkg::req_type              item,
   output logic [sih_pkg::HASH_W-1:0]    hash_fold
);
   import sih_pkg::*;

   logic [HASH_W-1:0] running_hash_ff;

   assign hash_fold = item.byte_present ? fnv_step(running_hash_ff, item.data_byte)
                                        : running_hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= FNV_BASIS;
      end else if (fold_en) begin
         running_hash_ff <= item.last ? FNV_BASIS : hash_fold;
      end
   end

endmodule

>>> hw/rtl/sih_ram.sv
module sih_ram (
   input  logic                          clock,
   input  sih_pkg::ram_cmd_type          cmd,
   output logic [sih_pkg::HASH_W-1:0]    rd_data
);
   import sih_pkg::*;

   logic [HASH_W-1:0] mem [ENTRIES];
   logic [HASH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/string_intern_hash_table_core.sv
// String interning core with a 64-bit FNV-1a hash and a fixed table.
// Input channel (req_): one string byte per transaction, with byte_present and
// a last mark. A byte transaction without the last mark gives no result;
// bytes may follow one per cycle while req_stall is low.
// On the transaction with the last mark the finished hash is compared against
// the stored hashes, one table read per cycle from index 1 upward through a
// synchronous memory with one read and one write port. With E stored strings a
// miss reads all E entries before the new hash is stored if there is room; a
// match at index k ends the search there. The result is then held in the finish
// step and loaded into the output register once it is free. req_stall stays
// high for the whole search and until the result is loaded.
// Result channel (rsp_): handle, found and table_full. A new hash goes to the
// next free index; a full table returns the null handle with table_full set.
// While rsp_stall holds a result, the core keeps taking bytes of the next
// string and only waits before loading the next result.
// Reset clears the running hash to the offset basis and the next free index
// to 1; table contents are not cleared, since only written entries are read.
module string_intern_hash_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sih_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sih_pkg::rsp_type  rsp_item
);
   import sih_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  next_index_ff;
   logic [CNT_W-1:0]  issue_idx_ff;
   logic [CNT_W-1:0]  pend_idx_ff;
   logic              pend_ff;
   logic [HASH_W-1:0] key_ff;
   rsp_type           res_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              req_accept;
   logic [HASH_W-1:0] hash_fold;
   logic [HASH_W-1:0] rd_data;
   logic              hit;
   logic              more;
   logic              table_is_full;
   ram_cmd_type       ram_cmd;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   sih_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .fold_en   (req_accept),
      .item      (req_item),
      .hash_fold (hash_fold)
   );

   sih_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (rd_data)
   );

   assign hit = pend_ff && (rd_data == key_ff);
   assign more = (issue_idx_ff < next_index_ff);
   assign table_is_full = (next_index_ff >= CNT_W'(ENTRIES));

   always_comb begin
      ram_cmd.rd_en = (state_ff == ST_SCAN) && !hit && more;
      ram_cmd.rd_addr = issue_idx_ff[IDX_W-1:0];
      ram_cmd.wr_en = (state_ff == ST_SCAN) && !hit && !more && !table_is_full;
      ram_cmd.wr_addr = next_index_ff[IDX_W-1:0];
      ram_cmd.wr_data = key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_index_ff <= CNT_W'(1);
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_item.last) begin
                  key_ff <= hash_fold;
                  issue_idx_ff <= CNT_W'(1);
                  pend_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  res_ff.handle <= to_handle(pend_idx_ff);
                  res_ff.found <= 1'b1;
                  res_ff.table_full <= 1'b0;
                  pend_ff <= 1'b0;
                  state_ff <= ST_FINISH;
               end else if (more) begin
                  pend_ff <= 1'b1;
                  pend_idx_ff <= issue_idx_ff;
                  issue_idx_ff <= issue_idx_ff + CNT_W'(1);
               end else begin
                  pend_ff <= 1'b0;
                  res_ff.found <= 1'b0;
                  if (table_is_full) begin
                     res_ff.handle <= '0;
                     res_ff.table_full <= 1'b1;
                  end else begin
                     res_ff.handle <= to_handle(next_index_ff);
                     res_ff.table_full <= 1'b0;
                     next_index_ff <= next_index_ff + CNT_W'(1);
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (next_index_ff != '0) && (next_index_ff <= CNT_W'(ENTRIES)))
      else $error("next free index out of range");

   a_write_advances: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.wr_en |=> (next_index_ff == $past(next_index_ff) + CNT_W'(1)))
      else $error("table write without index advance");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside finish step");

   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.table_full))
      else $error("result both found and full");

endmodule

>>> test/string_intern_hash_table_core_tb.sv
`timescale 1ns / 1ps

module string_intern_hash_table_core_tb;
   import sih_pkg::*;

   localparam logic [HASH_W-1:0] HASH_PRIME = 64'h00000100000001b3;
   localparam int DRAIN_CYCLES = ENTRIES + 40;

   typedef enum int {
      PHASE_STEADY,
      PHASE_REQ_GAPS,
      PHASE_RSP_STALLS,
      PHASE_BOTH
   } phase_type;

   typedef struct {
      logic [63:0] bytes;
      int          len;
   } string_type;

   class intern_scoreboard;
      logic [HASH_W-1:0] running_hash;
      int                next_index;
      logic [HASH_W-1:0] hash_store [ENTRIES];
      rsp_type           expected_rsp [$];

      function new();
         running_hash = FNV_BASIS;
         next_index = 1;
      endfunction

      function void note_request(req_type it);
         logic [HASH_W-1:0] h;
         int                hit;
         rsp_type           r;
         if (it.byte_present) begin
            running_hash = (running_hash ^ {56'd0, it.data_byte}) * HASH_PRIME;
         end
         if (!it.last) begin
            return;
         end
         h = running_hash;
         running_hash = FNV_BASIS;
         hit = 0;
         for (int k = 1; k < next_index && hit == 0; k++) begin
            if (hash_store[k] == h) begin
               hit = k;
            end
         end
         if (hit != 0) begin
            r.handle = HANDLE_W'(hit);
            r.found = 1'b1;
            r.table_full = 1'b0;
         end else if (next_index >= ENTRIES) begin
            r.handle = '0;
            r.found = 1'b0;
            r.table_full = 1'b1;
         end else begin
            hash_store[next_index] = h;
            r.handle = HANDLE_W'(next_index);
            r.found = 1'b0;
            r.table_full = 1'b0;
            next_index++;
         end
         expected_rsp.push_back(r);
      endfunction

      function string check_response(rsp_type got);
         rsp_type want;
         string   msg;
         msg = "";
         if (expected_rsp.size() == 0) begin
            return $sformatf("unexpected response: handle %0d found %0b table_full %0b",
                             got.handle, got.found, got.table_full);
         end
         want = expected_rsp.pop_front();
         if (got.handle !== want.handle) begin
            msg = {msg, $sformatf(" handle %0d (expected %0d)", got.handle, want.handle)};
         end
         if (got.found !== want.found) begin
            msg = {msg, $sformatf(" found %0b (expected %0b)", got.found, want.found)};
         end
         if (got.table_full !== want.table_full) begin
            msg = {msg, $sformatf(" table_full %0b (expected %0b)", got.table_full,
                                  want.table_full)};
         end
         if (msg != "") begin
            msg = {"response mismatch:", msg};
         end
         return msg;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function bit is_full();
         return next_index >= ENTRIES;
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   intern_scoreboard sb = new();
   string_type       history [$];
   int               error_count = 0;
   int               req_gap_pct = 0;
   int               rsp_stall_pct = 0;

   string_intern_hash_table_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report(input string msg);
      if (error_count < 50) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_item);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         msg = sb.check_response(rsp_item);
         if (msg != "") begin
            report(msg);
         end
      end
   end

   task automatic set_phase(input phase_type p);
      case (p)
         PHASE_STEADY: begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         PHASE_REQ_GAPS: begin
            req_gap_pct = 73;
            rsp_stall_pct = 0;
         end
         PHASE_RSP_STALLS: begin
            req_gap_pct = 0;
            rsp_stall_pct = 73;
         end
         default: begin
            req_gap_pct = 21;
            rsp_stall_pct = 21;
         end
      endcase
   endtask

   task automatic send_item(input req_type it);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_bare(input logic [7:0] b, input logic present, input logic last);
      req_type it;
      it.data_byte = b;
      it.byte_present = present;
      it.last = last;
      send_item(it);
   endtask

   task automatic send_string(input string_type s, input bit absent_end, input bit noisy);
      for (int i = 0; i < s.len; i++) begin
         if (noisy && $urandom_range(9) == 0) begin
            send_bare(8'($urandom), 1'b0, 1'b0);
         end
         send_bare(s.bytes[8*i +: 8], 1'b1, (i == s.len - 1) && !absent_end);
      end
      if (s.len == 0 || absent_end) begin
         send_bare(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   function automatic string_type random_string();
      string_type s;
      int         pick;
      pick = $urandom_range(9);
      s.bytes = {$urandom, $urandom};
      if (pick == 0) begin
         s.len = 0;
      end else if (pick <= 3) begin
         s.len = 1;
      end else if (pick <= 6) begin
         s.len = 2;
      end else if (pick <= 8) begin
         s.len = 3;
      end else begin
         s.len = $urandom_range(4, 8);
      end
      return s;
   endfunction

   initial begin : main
      string_type s;
      int         strings_after_full;
      int         random_items;
      set_phase(PHASE_STEADY);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The empty string interns the offset basis, and a second one finds it.
      send_bare(8'h00, 1'b0, 1'b1);
      send_bare(8'hff, 1'b0, 1'b1);
      send_bare(8'ha5, 1'b0, 1'b0);
      send_bare(8'h3c, 1'b0, 1'b1);
      send_bare(8'h00, 1'b1, 1'b1);
      send_bare(8'hff, 1'b1, 1'b1);
      send_bare(8'hff, 1'b1, 1'b0);
      send_bare(8'h12, 1'b0, 1'b1);
      send_bare(8'h41, 1'b1, 1'b0);
      send_bare(8'h5a, 1'b0, 1'b0);
      send_bare(8'h42, 1'b1, 1'b1);
      send_bare(8'h41, 1'b1, 1'b0);
      send_bare(8'h42, 1'b1, 1'b1);
      send_bare(8'h55, 1'b1, 1'b1);
      send_bare(8'haa, 1'b1, 1'b0);
      send_bare(8'h55, 1'b1, 1'b1);
      send_bare(8'h00, 1'b1, 1'b1);
      send_bare(8'h55, 1'b1, 1'b1);

      s.bytes = 64'h00000000000055aa;
      s.len = 2;
      history.push_back(s);
      s.bytes = 64'h0000000000004241;
      history.push_back(s);

      strings_after_full = 0;
      random_items = 0;
      while (random_items < 1000 || strings_after_full < 40) begin
         set_phase(phase_type'((random_items / 250) % 4));
         if ($urandom_range(19) == 0) begin
            send_bare(8'($urandom), 1'b0, 1'b0);
         end else begin
            if ($urandom_range(99) < 70) begin
               s = random_string();
               history.push_back(s);
            end else begin
               s = history[$urandom_range(history.size() - 1)];
            end
            random_items += s.len + 1;
            if (sb.is_full()) begin
               strings_after_full++;
            end
            send_string(s, $urandom_range(7) == 0, 1'b1);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/sih_pkg.sv
hw/rtl/sih_hash.sv
hw/rtl/sih_ram.sv
hw/rtl/string_intern_hash_table_core.sv
test/string_intern_hash_table_core_tb.sv
